// ===== src/vrgd_pkg.sv =====
// Shared types, sizes, register indexes and saturating arithmetic for the row fit.
// No dependencies; used by vrgd_cell and var_row_gradient_descent.
`default_nettype none
package vrgd_pkg;

    localparam int MAX_SERIES = 16;
    localparam int MAX_TIME   = 256;

    localparam logic [2:0] CFG_SERIES_COUNT    = 3'd0;
    localparam logic [2:0] CFG_TIME_LENGTH     = 3'd1;
    localparam logic [2:0] CFG_ITERATION_COUNT = 3'd2;
    localparam logic [2:0] CFG_STEP_SIZE       = 3'd3;

    typedef enum logic [3:0] {
        C_IDLE,
        C_CLEAR,
        C_LOADX,
        C_MUL_AX,
        C_CHAIN,
        C_MUL_RX,
        C_ACC_G,
        C_CLR_G,
        C_MUL_LO,
        C_MUL_HI,
        C_UPD
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] data;
        logic signed [31:0] res;
        logic [31:0]        step;
    } t_cell_ctl;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/vrgd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module vrgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/vrgd_cell.sv =====
// One coefficient cell: holds a_k, x_k[t] and g_k, one shared multiplier,
// and one link of the saturating partial-sum chain. Depends on vrgd_pkg.
`default_nettype none
module vrgd_cell (
    input  wire logic                i_clk,
    input  wire vrgd_pkg::t_cell_ctl i_ctl,
    input  wire logic                i_en,
    input  wire logic                i_ld,
    input  wire logic signed [63:0]  i_psum,
    output logic signed [63:0]       o_psum,
    output logic signed [31:0]       o_a
);
    import vrgd_pkg::*;

    logic signed [31:0] r_a, r_x;
    logic signed [63:0] r_g;
    logic [63:0]        r_p, r_lo;
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    logic [63:0]        w_mag, w_q;
    logic signed [63:0] w_d;

    assign w_mag = r_g[63] ? (64'd0 - r_g) : r_g;
    assign w_q   = (r_p + {32'd0, r_lo[63:32]}) >> 16;
    assign w_d   = r_g[63] ? -$signed(w_q) : $signed(w_q);

    always_comb begin
        w_ma = {r_a[31], r_a};
        w_mb = {r_x[31], r_x};
        case (i_ctl.op)
            C_MUL_RX: w_ma = {i_ctl.res[31], i_ctl.res};
            C_MUL_LO: begin
                w_ma = {1'b0, w_mag[31:0]};
                w_mb = {1'b0, i_ctl.step};
            end
            C_MUL_HI: begin
                w_ma = {1'b0, w_mag[63:32]};
                w_mb = {1'b0, i_ctl.step};
            end
            default: ;
        endcase
    end
    assign w_prod = w_ma * w_mb;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            C_CLEAR:  r_a <= '0;
            C_LOADX:  if (i_ld) r_x <= i_ctl.data;
            C_MUL_AX: r_p <= w_prod[63:0];
            C_CHAIN:  o_psum <= i_en ? sat_add64(i_psum, r_p) : i_psum;
            C_MUL_RX: r_p <= w_prod[63:0];
            C_ACC_G:  r_g <= sat_add64(r_g, r_p);
            C_CLR_G:  r_g <= '0;
            C_MUL_LO: r_p <= w_prod[63:0];
            C_MUL_HI: begin
                r_lo <= r_p;
                r_p  <= w_prod[63:0];
            end
            C_UPD:    if (i_en) r_a <= sat32({{32{r_a[31]}}, r_a} - w_d);
            default: ;
        endcase
    end

    assign o_a = r_a;
endmodule
`default_nettype wire

// ===== src/var_row_gradient_descent.sv =====
// Row fit of a first-order vector autoregression by gradient descent.
// Loads are accepted one per cycle while no fit is running (o_stall low). A start
// reads one sample per cycle and walks the partial sum down the cell chain for
// each time step and iteration, then emits N coefficients.
// Reset (synchronous, active low) restores the register defaults; the sample store is not cleared.
`default_nettype none
module var_row_gradient_descent (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_kind,
    input  wire logic [3:0]         i_series_row,
    input  wire logic [7:0]         i_time_index,
    input  wire logic signed [31:0] i_sample_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [3:0]              o_coefficient_index,
    output logic signed [31:0]      o_coefficient,
    output logic                    o_last,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import vrgd_pkg::*;

    localparam int DEPTH = MAX_SERIES * MAX_TIME;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_SERIES);
    localparam int NW    = $clog2(MAX_SERIES + 1);
    localparam int TCW   = $clog2(MAX_TIME + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_CLRG, S_READ, S_WAIT, S_MULAX, S_CHAIN, S_RES,
        S_MULRX, S_ACCG, S_MULLO, S_MULHI, S_UPD, S_EMIT
    } t_state;

    t_state             r_state;
    logic [4:0]         r_cfg_n;
    logic [8:0]         r_cfg_t;
    logic [15:0]        r_cfg_it;
    logic [31:0]        r_cfg_step;
    logic [NW-1:0]      r_n, r_j, r_rd_tag;
    logic [TCW-1:0]     r_tl, r_t;
    logic [RW-1:0]      r_tgt_row, r_cc, r_k;
    logic [15:0]        r_it;
    logic               r_rd_vld;
    logic signed [31:0] r_tgt, r_res;

    logic               w_in_acc, w_we;
    logic [AW-1:0]      w_waddr, w_raddr, w_rrow, w_rt;
    logic [31:0]        w_rdata;
    t_cell_ctl          w_ctl;
    logic signed [63:0] w_psum [MAX_SERIES+1];
    logic signed [31:0] w_a    [MAX_SERIES];
    logic signed [63:0] w_tneg, w_acc, w_sh;

    assign w_in_acc = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign w_we     = w_in_acc && !i_kind && (32'(i_series_row) < MAX_SERIES)
                      && (32'(i_time_index) < MAX_TIME);
    assign w_waddr  = AW'(i_series_row) * AW'(MAX_TIME) + AW'(i_time_index);
    assign w_rrow   = (r_j < r_n) ? AW'(r_j) : AW'(r_tgt_row);
    assign w_rt     = (r_j < r_n) ? AW'(r_t) : AW'(r_t) + AW'(1);
    assign w_raddr  = w_rrow * AW'(MAX_TIME) + w_rt;

    vrgd_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(i_sample_value),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_ctl.data = w_rdata;
        w_ctl.res  = r_res;
        w_ctl.step = r_cfg_step;
        case (r_state)
            S_CLR:   w_ctl.op = C_CLEAR;
            S_CLRG:  w_ctl.op = (r_it == r_cfg_it) ? C_IDLE : C_CLR_G;
            S_READ:  w_ctl.op = C_LOADX;
            S_WAIT:  w_ctl.op = C_LOADX;
            S_MULAX: w_ctl.op = C_MUL_AX;
            S_CHAIN: w_ctl.op = C_CHAIN;
            S_MULRX: w_ctl.op = C_MUL_RX;
            S_ACCG:  w_ctl.op = C_ACC_G;
            S_MULLO: w_ctl.op = C_MUL_LO;
            S_MULHI: w_ctl.op = C_MUL_HI;
            S_UPD:   w_ctl.op = C_UPD;
            default: w_ctl.op = C_IDLE;
        endcase
    end

    assign w_psum[0] = '0;
    for (genvar k = 0; k < MAX_SERIES; k++) begin : g_cell
        vrgd_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (w_ctl),
            .i_en  (NW'(k) < r_n),
            .i_ld  (r_rd_vld && (r_rd_tag == NW'(k))),
            .i_psum(w_psum[k]),
            .o_psum(w_psum[k+1]),
            .o_a   (w_a[k])
        );
    end

    assign w_tneg = -{{16{r_tgt[31]}}, r_tgt, 16'd0};
    assign w_acc  = sat_add64(w_psum[MAX_SERIES], w_tneg);
    assign w_sh   = w_acc >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg_n    <= 5'd16;
            r_cfg_t    <= 9'd256;
            r_cfg_it   <= 16'd100;
            r_cfg_step <= 32'd28939263;
            r_rd_vld   <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SERIES_COUNT:    r_cfg_n    <= i_cfg_data[4:0];
                    CFG_TIME_LENGTH:     r_cfg_t    <= i_cfg_data[8:0];
                    CFG_ITERATION_COUNT: r_cfg_it   <= i_cfg_data[15:0];
                    CFG_STEP_SIZE:       r_cfg_step <= i_cfg_data;
                    default: ;
                endcase
            end
            r_rd_vld <= (r_state == S_READ);
            r_rd_tag <= r_j;
            if (r_rd_vld && r_rd_tag == r_n) r_tgt <= w_rdata;
            if (o_valid && !i_stall && r_state != S_EMIT) o_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_kind) begin
                        r_n  <= (r_cfg_n < 5'd2) ? NW'(2) :
                                (32'(r_cfg_n) > MAX_SERIES) ? NW'(MAX_SERIES) : NW'(r_cfg_n);
                        r_tl <= (r_cfg_t < 9'd3) ? TCW'(3) :
                                (32'(r_cfg_t) > MAX_TIME) ? TCW'(MAX_TIME) : TCW'(r_cfg_t);
                        r_tgt_row <= (32'(i_series_row) < MAX_SERIES) ?
                                     RW'(i_series_row) : RW'(MAX_SERIES - 1);
                        r_state <= S_CLR;
                    end
                end
                S_CLR: begin
                    r_it    <= '0;
                    r_state <= S_CLRG;
                end
                S_CLRG: begin
                    r_t <= '0;
                    r_j <= '0;
                    r_k <= '0;
                    r_state <= (r_it == r_cfg_it) ? S_EMIT : S_READ;
                end
                S_READ: begin
                    r_j <= r_j + NW'(1);
                    if (r_j == r_n) r_state <= S_WAIT;
                end
                S_WAIT:  r_state <= S_MULAX;
                S_MULAX: begin
                    r_cc    <= '0;
                    r_state <= S_CHAIN;
                end
                S_CHAIN: begin
                    r_cc <= r_cc + RW'(1);
                    if (r_cc == RW'(MAX_SERIES - 1)) r_state <= S_RES;
                end
                S_RES: begin
                    r_res   <= sat32(w_sh);
                    r_state <= S_MULRX;
                end
                S_MULRX: r_state <= S_ACCG;
                S_ACCG: begin
                    r_j <= '0;
                    r_t <= r_t + TCW'(1);
                    r_state <= (r_t + TCW'(2) == r_tl) ? S_MULLO : S_READ;
                end
                S_MULLO: r_state <= S_MULHI;
                S_MULHI: r_state <= S_UPD;
                S_UPD: begin
                    r_it    <= r_it + 16'd1;
                    r_state <= S_CLRG;
                end
                S_EMIT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid             <= 1'b1;
                        o_coefficient_index <= 4'(r_k);
                        o_coefficient       <= w_a[r_k];
                        o_last              <= (NW'(r_k) + NW'(1) == r_n);
                        r_k <= r_k + RW'(1);
                        if (NW'(r_k) + NW'(1) == r_n) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_kind) |=> o_stall)
        else $error("start transaction did not make the block busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_coefficient_index)
                                  && $stable(o_coefficient) && $stable(o_last)))
        else $error("stalled output transaction changed");
    a_read_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ($past(r_state) == S_READ))
        else $error("read data valid without a read");
endmodule
`default_nettype wire

// ===== tb/var_row_gradient_descent_tb.sv =====
// Testbench for var_row_gradient_descent: directed and random loads and fits checked against a
// behavioral fit predictor held in a small scoreboard class. Depends on vrgd_pkg.
`timescale 1ns / 100ps

module var_row_gradient_descent_tb;
    import vrgd_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_START = 1'b1;
    localparam int   STALL_LIMIT = 100000;

    typedef struct {
        logic [3:0]         idx;
        logic signed [31:0] coef;
        logic               last;
    } t_coef;

    class fit_scoreboard;
        logic [4:0]  n_reg;
        logic [8:0]  t_reg;
        logic [15:0] iter_reg;
        logic [31:0] step_reg;
        int          samples[16][256];
        bit          written[16][256];
        t_coef       coef_q[$];
        int          errors;

        function new();
            n_reg = 5'd16;
            t_reg = 9'd256;
            iter_reg = 16'd100;
            step_reg = 32'd28939263;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_SERIES_COUNT:    n_reg = val[4:0];
                CFG_TIME_LENGTH:     t_reg = val[8:0];
                CFG_ITERATION_COUNT: iter_reg = val[15:0];
                CFG_STEP_SIZE:       step_reg = val;
                default: ;
            endcase
        endfunction

        function int eff_n();
            return n_reg < 2 ? 2 : (n_reg > 16 ? 16 : int'(n_reg));
        endfunction

        function int eff_t();
            return t_reg < 3 ? 3 : (t_reg > 256 ? 256 : int'(t_reg));
        endfunction

        function longint add_sat(longint a, longint b);
            logic signed [64:0] s;
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
                return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            return s[63:0];
        endfunction

        function int clamp32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function longint step_delta(longint g);
            logic [63:0] mag;
            logic [95:0] prod;
            longint      d;
            mag = g < 0 ? 64'd0 - g : g;
            prod = {32'd0, mag} * {64'd0, step_reg};
            d = prod[95:48];
            return g < 0 ? -d : d;
        endfunction

        function void run_fit(int target);
            int     n, tl, acc_n;
            int     coef[16];
            longint resid[256];
            longint grad[16];
            longint acc;
            t_coef  e;
            n = eff_n();
            tl = eff_t();
            for (int k = 0; k < 16; k++) coef[k] = 0;
            for (int it = 0; it < iter_reg; it++) begin
                for (int t = 0; t + 1 < tl; t++) begin
                    acc = 0;
                    for (int j = 0; j < n; j++)
                        acc = add_sat(acc, longint'(coef[j]) * longint'(samples[j][t]));
                    acc = add_sat(acc, -(longint'(samples[target][t+1]) * 65536));
                    resid[t] = clamp32(acc >>> 16);
                end
                for (int k = 0; k < n; k++) begin
                    acc = 0;
                    for (int t = 0; t + 1 < tl; t++)
                        acc = add_sat(acc, resid[t] * longint'(samples[k][t]));
                    grad[k] = acc;
                end
                for (int k = 0; k < n; k++)
                    coef[k] = clamp32(longint'(coef[k]) - step_delta(grad[k]));
            end
            for (int k = 0; k < n; k++) begin
                e.idx = 4'(k);
                e.coef = coef[k];
                e.last = (k == n - 1);
                coef_q.push_back(e);
            end
        endfunction

        function void note_input(logic kind, logic [3:0] row, logic [7:0] ti,
                                 logic signed [31:0] val);
            if (kind == KIND_LOAD) begin
                samples[row][ti] = val;
                written[row][ti] = 1;
            end else begin
                run_fit(row);
            end
        endfunction

        function void check_result(logic [3:0] idx, logic signed [31:0] coef, logic last);
            t_coef e;
            if (coef_q.size() == 0) begin
                $display("%0t: unexpected result idx=%0d coef=%0d last=%0b",
                         $time, idx, coef, last);
                errors++;
                return;
            end
            e = coef_q.pop_front();
            if (idx !== e.idx) begin
                $display("%0t: coefficient_index expected %0d actual %0d", $time, e.idx, idx);
                errors++;
            end
            if (coef !== e.coef) begin
                $display("%0t: coefficient[%0d] expected %0d actual %0d",
                         $time, e.idx, e.coef, coef);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last[%0d] expected %0b actual %0b", $time, e.idx, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_stall;
    logic               i_kind = 0;
    logic [3:0]         i_series_row = 0;
    logic [7:0]         i_time_index = 0;
    logic signed [31:0] i_sample_value = 0;
    logic               o_valid;
    logic               i_stall = 1;
    logic [3:0]         o_coefficient_index;
    logic signed [31:0] o_coefficient;
    logic               o_last;
    logic               i_cfg_we = 0;
    logic [2:0]         i_cfg_index = 0;
    logic [31:0]        i_cfg_data = 0;

    fit_scoreboard sb = new();
    bit  quiet = 0;
    bit  hold_req = 0;
    int  idle_cnt = 0;
    int  item_cnt = 0;

    var_row_gradient_descent i_dut (.*);

    always #6 i_clk = ~i_clk;

    function int draw_gap();
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    function logic signed [31:0] rand_sample();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
        endcase
    endfunction

    task automatic send_item(logic kind, logic [3:0] row, logic [7:0] ti,
                             logic signed [31:0] val);
        int  gap;
        bit  fire;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_kind <= kind;
        i_series_row <= row;
        i_time_index <= ti;
        i_sample_value <= val;
        do begin
            @(negedge i_clk);
            fire = !o_stall;
            @(posedge i_clk);
        end while (!fire);
        sb.note_input(kind, row, ti, val);
        item_cnt++;
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.coef_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    // Loads whatever samples the next fit reads and that were never written, then sends the start.
    task automatic start_fit(logic [3:0] target);
        for (int r = 0; r < 16; r++) begin
            if (r < sb.eff_n() || r == target) begin
                for (int t = 0; t < sb.eff_t(); t++)
                    if (!sb.written[r][t])
                        send_item(KIND_LOAD, 4'(r), 8'(t), rand_sample());
            end
        end
        send_item(KIND_START, target, 8'($urandom), 32'($urandom));
    endtask

    // Receiver
    initial begin
        int  gap;
        bit  fire;
        logic [3:0]         idx;
        logic signed [31:0] coef;
        logic               last;
        @(posedge i_rst_n);
        forever begin
            gap = draw_gap();
            if (hold_req) begin
                hold_req = 0;
                gap = 400;
            end
            if (gap > 0) begin
                i_stall <= 1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 0;
            do begin
                @(negedge i_clk);
                fire = o_valid;
                idx = o_coefficient_index;
                coef = o_coefficient;
                last = o_last;
                @(posedge i_clk);
            end while (!fire);
            sb.check_result(idx, coef, last);
        end
    end

    // Watchdog
    always @(negedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= STALL_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part
        write_reg(CFG_UNUSED, 32'h0000_0001);
        write_reg(CFG_ITERATION_COUNT, 32'h0000_FFFF);
        send_item(KIND_LOAD, 4'd0, 8'd0, 32'sh7FFFFFFF);
        send_item(KIND_LOAD, 4'd15, 8'd255, 32'sh80000000);
        send_item(KIND_LOAD, 4'd1, 8'd1, 32'sd0);
        send_item(KIND_LOAD, 4'd15, 8'd0, -32'sd1);
        drain();
        write_reg(CFG_ITERATION_COUNT, 32'd0);
        write_reg(CFG_SERIES_COUNT, 32'd2);
        write_reg(CFG_TIME_LENGTH, 32'd3);
        start_fit(4'd0);
        drain();
        write_reg(CFG_ITERATION_COUNT, 32'd2);
        write_reg(CFG_STEP_SIZE, 32'hFFFF_FFFF);
        write_reg(CFG_SERIES_COUNT, 32'd0);
        write_reg(CFG_TIME_LENGTH, 32'd0);
        start_fit(4'd15);
        drain();
        write_reg(CFG_SERIES_COUNT, 32'd31);
        write_reg(CFG_STEP_SIZE, 32'd0);
        start_fit(4'd3);
        drain();
        write_reg(CFG_SERIES_COUNT, 32'd1);
        write_reg(CFG_TIME_LENGTH, 32'd10);
        write_reg(CFG_ITERATION_COUNT, 32'd1);
        write_reg(CFG_STEP_SIZE, 32'd28939263);
        start_fit(4'd1);
        drain();

        // Random part
        for (int ph = 0; item_cnt < 400 || ph < 2; ph++) begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0 || ph == 0) begin
                drain();
                write_reg(CFG_SERIES_COUNT, $urandom_range(0, 31));
                write_reg(CFG_TIME_LENGTH, $urandom_range(0, 14));
                write_reg(CFG_ITERATION_COUNT, $urandom_range(0, 6));
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_STEP_SIZE, $urandom);
                    1: write_reg(CFG_STEP_SIZE, 32'd0);
                    default: write_reg(CFG_STEP_SIZE, $urandom_range(1 << 20, 1 << 28));
                endcase
            end
            repeat ($urandom_range(2, 12)) begin
                if ($urandom_range(0, 3) == 0)
                    send_item(KIND_LOAD, 4'($urandom), 8'($urandom), rand_sample());
                else
                    send_item(KIND_LOAD, 4'($urandom_range(0, sb.eff_n() - 1)),
                              8'($urandom_range(0, sb.eff_t() - 1)), rand_sample());
            end
            if (ph == 1) hold_req = 1;
            if ($urandom_range(0, 3) == 0)
                start_fit(4'($urandom));
            else
                start_fit(4'($urandom_range(0, sb.eff_n() - 1)));
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.coef_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
